/* rtl/lbr_pkg.sv */
// ----------------------------------------------------------------------------
// lbr_pkg
// shared types and constants of the letterbox bilinear resize block
// ----------------------------------------------------------------------------
package lbr_pkg;

  localparam int MaxSrcSideDef = 256;
  localparam int MaxTargetDef  = 1024;

  localparam int SrcRegW  = 9;
  localparam int TgtRegW  = 11;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 11;
  localparam int ScaleW   = 27;
  localparam int ChanW    = 16;

  localparam logic [SrcRegW-1:0] SrcSideRst = 9'd256;
  localparam logic [TgtRegW-1:0] TargetRst  = 11'd640;

  localparam logic KindLoad  = 1'b0;
  localparam logic KindQuery = 1'b1;

  // 114/255 in q1.15, truncated
  localparam logic [ChanW-1:0] GreyQ15 = 16'd14649;
  // half a source pixel in q16.16
  localparam int HalfPixel = 32768;
  // ceil(2^32 / 255), exact for quotients of values below 2^23
  localparam logic [24:0] Recip255 = 25'd16843010;
  localparam int RecipShift = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SRC_WIDTH   = 2'd0,
    CFG_SRC_HEIGHT  = 2'd1,
    CFG_TARGET_SIDE = 2'd2
  } lbr_cfg_idx_e;

  typedef enum logic [1:0] {
    DQ_SCALE  = 2'd0,
    DQ_INV    = 2'd1,
    DQ_WIDTH  = 2'd2,
    DQ_HEIGHT = 2'd3
  } lbr_div_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DLOAD,
    ST_DIV,
    ST_DMUL,
    ST_DPAD,
    ST_CHECK,
    ST_MULX,
    ST_CLPX,
    ST_MULY,
    ST_CLPY,
    ST_READ,
    ST_ACC,
    ST_NORM,
    ST_DONE
  } lbr_state_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] src_col;
    logic [7:0] src_row;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [9:0] dst_col;
    logic [9:0] dst_row;
  } lbr_in_t;

  typedef struct packed {
    logic [ChanW-1:0]  red_out;
    logic [ChanW-1:0]  green_out;
    logic [ChanW-1:0]  blue_out;
    logic              is_padding;
    logic              out_of_range;
    logic [9:0]        pad_left;
    logic [9:0]        pad_top;
    logic [ScaleW-1:0] scale_fixed;
  } lbr_out_t;

endpackage

/* rtl/letterbox_bilinear_resize.sv */
// ----------------------------------------------------------------------------
// letterbox_bilinear_resize
// letterbox fit of a stored rgb frame into a square target, bilinear samples
// ----------------------------------------------------------------------------
//  port group  dir  handshake                payload
//  in          in   in_valid_i / in_stall_o  lbr_in_t   (load or query)
//  out         out  out_valid_o / out_stall_i lbr_out_t (one per query)
//  cfg         in   cfg_valid_i / cfg_ready_o index + data
//
//  a load is written into the frame store in the cycle it is accepted
//  a content query maps its coordinates on the shared multiplier, then does
//  four single-port frame store reads, three accumulates each, and a
//  three-step normalize; border and out-of-range queries skip to the result
//  the first query after reset or a register write first runs four divisions
//  on a one-bit-per-cycle divider
//  the output register lets a new request in while a result is stalled
//  the frame store is not cleared by reset
// ----------------------------------------------------------------------------
module letterbox_bilinear_resize
  import lbr_pkg::*;
#(
  parameter int MAX_SRC_SIDE = MaxSrcSideDef,
  parameter int MAX_TARGET   = MaxTargetDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lbr_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lbr_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int SW       = $clog2(MAX_SRC_SIDE + 1);
  localparam int TW       = $clog2(MAX_TARGET + 1);
  localparam int NWA      = ((TW > SW) ? TW : SW) + 16;
  localparam int NWB      = SW + TW + 1;
  localparam int NW       = (NWA > NWB) ? NWA : NWB;
  localparam int CNW      = $clog2(NW);
  localparam int DVW      = (SW + 1 > TW) ? SW + 1 : TW;
  localparam int MA       = (TW + 1 > 23) ? TW + 1 : 23;
  localparam int MB       = (SW + 16 > 25) ? SW + 16 : 25;
  localparam int CW       = SW + 16;
  localparam int PQW      = TW + 1 + SW + 16;
  localparam int MemDepth = MAX_SRC_SIDE * MAX_SRC_SIDE;
  localparam int AW       = $clog2(MemDepth);

  lbr_state_e state_q, state_d;

  logic [SrcRegW-1:0] src_width_q, src_height_q;
  logic [TgtRegW-1:0] target_side_q;
  logic               dirty_q;

  lbr_div_sel_e   sel_q;
  logic [CNW-1:0] cnt_q;
  logic [1:0]     corner_q, chan_q;

  logic [NW-1:0]     num_q;
  logic [DVW-1:0]    dvs_q, rem_q;
  logic [ScaleW-1:0] scale_q;
  logic [CW-1:0]     inv_q;
  logic [TW-1:0]     new_w_q, new_h_q, pad_l_q, pad_t_q, dx_q, dy_q;
  logic [9:0]        qcol_q, qrow_q;
  logic [PQW-1:0]    prod_q;
  logic [SW-1:0]     x0_q, x1_q, y0_q, y1_q;
  logic [7:0]        fx_q, fy_q;
  logic [16:0]       wgt_q;
  logic [23:0]       acc_q [3];
  logic [ChanW-1:0]  color_q [3];
  logic              res_pad_q, res_oor_q;
  logic [23:0]       mem_rd_q;
  logic [23:0]       frame_store_q [MemDepth];
  lbr_out_t          out_q;
  logic              out_valid_q;

  // clamped register values
  logic [SW-1:0] w_c, h_c, longer;
  logic [TW-1:0] t_c;

  always_comb begin
    if (src_width_q == '0) begin
      w_c = SW'(1);
    end else if (32'(src_width_q) > MAX_SRC_SIDE) begin
      w_c = SW'(MAX_SRC_SIDE);
    end else begin
      w_c = SW'(src_width_q);
    end
    if (src_height_q == '0) begin
      h_c = SW'(1);
    end else if (32'(src_height_q) > MAX_SRC_SIDE) begin
      h_c = SW'(MAX_SRC_SIDE);
    end else begin
      h_c = SW'(src_height_q);
    end
    if (target_side_q == '0) begin
      t_c = TW'(1);
    end else if (32'(target_side_q) > MAX_TARGET) begin
      t_c = TW'(MAX_TARGET);
    end else begin
      t_c = TW'(target_side_q);
    end
    longer = (w_c > h_c) ? w_c : h_c;
  end

  // handshakes
  logic in_acc, is_query, is_load, out_free, out_load;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign is_query    = in_acc && (in_data_i.kind == KindQuery);
  assign is_load     = in_acc && (in_data_i.kind == KindLoad);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == ST_DONE) && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // dividend and divisor of each derived quantity
  logic [NW-1:0]  div_num;
  logic [DVW-1:0] div_den;

  always_comb begin
    case (sel_q)
      DQ_SCALE: begin
        div_num = NW'({t_c, 16'b0}) + NW'(longer >> 1);
        div_den = DVW'(longer);
      end
      DQ_INV: begin
        div_num = NW'({longer, 16'b0}) + NW'(t_c >> 1);
        div_den = DVW'(t_c);
      end
      default: begin
        div_num = NW'({prod_q[SW+TW-1:0], 1'b0}) + NW'(longer);
        div_den = DVW'({longer, 1'b0});
      end
    endcase
  end

  // restoring divider step
  logic [DVW:0]   div_shift, div_diff;
  logic           div_ge, div_last;
  logic [DVW-1:0] rem_n;
  logic [NW-1:0]  num_n;

  always_comb begin
    div_shift = {rem_q, num_q[NW-1]};
    div_diff  = div_shift - {1'b0, dvs_q};
    div_ge    = (div_shift >= {1'b0, dvs_q});
    rem_n     = div_ge ? div_diff[DVW-1:0] : div_shift[DVW-1:0];
    num_n     = {num_q[NW-2:0], div_ge};
    div_last  = (cnt_q == CNW'(NW - 1));
  end

  // query classification
  logic q_oor, q_pad;

  always_comb begin
    q_oor = (32'(qcol_q) >= 32'(t_c)) || (32'(qrow_q) >= 32'(t_c));
    q_pad = (32'(qcol_q) < 32'(pad_l_q)) ||
            (32'(qcol_q) - 32'(pad_l_q) >= 32'(new_w_q)) ||
            (32'(qrow_q) < 32'(pad_t_q)) ||
            (32'(qrow_q) - 32'(pad_t_q) >= 32'(new_h_q));
  end

  // source coordinate clamp
  logic [PQW-2:0] cl_half, cl_top, cl_s;
  logic [SW-1:0]  cl_len, cl_int, cl_next;
  logic [CW-1:0]  cl_coord;
  logic [7:0]     cl_frac;

  always_comb begin
    cl_half = prod_q[PQW-1:1];
    cl_len  = (state_q == ST_CLPY) ? h_c : w_c;
    cl_top  = (PQW-1)'({cl_len - SW'(1), 16'b0});
    if (cl_half < (PQW-1)'(HalfPixel)) begin
      cl_s = '0;
    end else begin
      cl_s = cl_half - (PQW-1)'(HalfPixel);
    end
    if (cl_s > cl_top) begin
      cl_s = cl_top;
    end
    cl_coord = CW'(cl_s);
    cl_int   = cl_coord[CW-1:16];
    cl_frac  = cl_coord[15:8];
    cl_next  = ({1'b0, cl_int} + (SW+1)'(1) < {1'b0, cl_len}) ? cl_int + SW'(1) : cl_int;
  end

  // corner selection, weights, pixel byte
  logic [SW-1:0] xs, ys;
  logic [8:0]    wx, wy;
  logic [7:0]    pix;
  logic [22:0]   norm_m;
  logic [23:0]   acc_cur;

  always_comb begin
    xs  = corner_q[0] ? x1_q : x0_q;
    ys  = corner_q[1] ? y1_q : y0_q;
    wx  = corner_q[0] ? {1'b0, fx_q} : 9'd256 - {1'b0, fx_q};
    wy  = corner_q[1] ? {1'b0, fy_q} : 9'd256 - {1'b0, fy_q};
    case (chan_q)
      2'd0:    pix = mem_rd_q[23:16];
      2'd1:    pix = mem_rd_q[15:8];
      default: pix = mem_rd_q[7:0];
    endcase
    case (chan_q)
      2'd0:    acc_cur = acc_q[0];
      2'd1:    acc_cur = acc_q[1];
      default: acc_cur = acc_q[2];
    endcase
    norm_m = 23'((25'(acc_cur) + 25'd255) >> 1);
  end

  // shared multiplier
  logic [MA-1:0]    opa;
  logic [MB-1:0]    opb;
  logic [MA+MB-1:0] mul_p;

  always_comb begin
    case (state_q)
      ST_DMUL: begin
        opa = MA'((sel_q == DQ_WIDTH) ? w_c : h_c);
        opb = MB'(t_c);
      end
      ST_MULX: begin
        opa = MA'({dx_q, 1'b1});
        opb = MB'(inv_q);
      end
      ST_MULY: begin
        opa = MA'({dy_q, 1'b1});
        opb = MB'(inv_q);
      end
      ST_READ: begin
        opa = MA'(wx);
        opb = MB'(wy);
      end
      ST_ACC: begin
        opa = MA'(pix);
        opb = MB'(wgt_q);
      end
      ST_NORM: begin
        opa = MA'(norm_m);
        opb = MB'(Recip255);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    mul_p = (MA+MB)'(opa) * (MA+MB)'(opb);
  end

  // frame store port
  logic          mem_we, mem_re, ld_in_range;
  logic [AW-1:0] mem_addr;

  always_comb begin
    ld_in_range = (32'(in_data_i.src_col) < MAX_SRC_SIDE) &&
                  (32'(in_data_i.src_row) < MAX_SRC_SIDE);
    mem_we      = is_load && ld_in_range;
    mem_re      = (state_q == ST_READ);
    if (mem_re) begin
      mem_addr = AW'(ys) * AW'(MAX_SRC_SIDE) + AW'(xs);
    end else begin
      mem_addr = AW'(in_data_i.src_row) * AW'(MAX_SRC_SIDE) + AW'(in_data_i.src_col);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_store_q[mem_addr] <= {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
    end else if (mem_re) begin
      mem_rd_q <= frame_store_q[mem_addr];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (is_query) begin
          state_d = dirty_q ? ST_DLOAD : ST_CHECK;
        end
      end
      ST_DLOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (div_last) begin
          case (sel_q)
            DQ_SCALE:  state_d = ST_DLOAD;
            DQ_HEIGHT: state_d = ST_DPAD;
            default:   state_d = ST_DMUL;
          endcase
        end
      end
      ST_DMUL:  state_d = ST_DLOAD;
      ST_DPAD:  state_d = ST_CHECK;
      ST_CHECK: state_d = (q_oor || q_pad) ? ST_DONE : ST_MULX;
      ST_MULX:  state_d = ST_CLPX;
      ST_CLPX:  state_d = ST_MULY;
      ST_MULY:  state_d = ST_CLPY;
      ST_CLPY:  state_d = ST_READ;
      ST_READ:  state_d = ST_ACC;
      ST_ACC: begin
        if (chan_q == 2'd2) begin
          state_d = (corner_q == 2'd3) ? ST_NORM : ST_READ;
        end
      end
      ST_NORM: begin
        if (chan_q == 2'd2) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q   <= SrcSideRst;
      src_height_q  <= SrcSideRst;
      target_side_q <= TargetRst;
      dirty_q       <= 1'b1;
      sel_q         <= DQ_SCALE;
      cnt_q         <= '0;
      corner_q      <= '0;
      chan_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        dirty_q <= 1'b1;
        case (cfg_index_i)
          CFG_SRC_WIDTH:   src_width_q   <= cfg_data_i[SrcRegW-1:0];
          CFG_SRC_HEIGHT:  src_height_q  <= cfg_data_i[SrcRegW-1:0];
          CFG_TARGET_SIDE: target_side_q <= cfg_data_i[TgtRegW-1:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE:  sel_q <= DQ_SCALE;
        ST_DLOAD: cnt_q <= '0;
        ST_DIV: begin
          cnt_q <= cnt_q + CNW'(1);
          if (div_last && sel_q != DQ_HEIGHT) begin
            sel_q <= lbr_div_sel_e'(sel_q + 2'd1);
          end
        end
        ST_DPAD: dirty_q <= 1'b0;
        ST_CHECK: begin
          corner_q <= '0;
          chan_q   <= '0;
        end
        ST_READ: chan_q <= '0;
        ST_ACC: begin
          if (chan_q == 2'd2) begin
            chan_q   <= '0;
            corner_q <= corner_q + 2'd1;
          end else begin
            chan_q <= chan_q + 2'd1;
          end
        end
        ST_NORM: chan_q <= chan_q + 2'd1;
        default: ;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (is_query) begin
          qcol_q <= in_data_i.dst_col;
          qrow_q <= in_data_i.dst_row;
        end
      end
      ST_DLOAD: begin
        num_q <= div_num;
        dvs_q <= div_den;
        rem_q <= '0;
      end
      ST_DIV: begin
        num_q <= num_n;
        rem_q <= rem_n;
        if (div_last) begin
          case (sel_q)
            DQ_SCALE: scale_q <= ScaleW'(num_n);
            DQ_INV:   inv_q   <= CW'(num_n);
            DQ_WIDTH: new_w_q <= TW'(num_n);
            default:  new_h_q <= TW'(num_n);
          endcase
        end
      end
      ST_DMUL: prod_q <= PQW'(mul_p);
      ST_DPAD: begin
        pad_l_q <= (t_c - new_w_q) >> 1;
        pad_t_q <= (t_c - new_h_q) >> 1;
      end
      ST_CHECK: begin
        dx_q      <= TW'(qcol_q) - pad_l_q;
        dy_q      <= TW'(qrow_q) - pad_t_q;
        res_oor_q <= q_oor;
        res_pad_q <= !q_oor && q_pad;
        for (int i = 0; i < 3; i++) begin
          acc_q[i]   <= '0;
          color_q[i] <= (!q_oor && q_pad) ? GreyQ15 : '0;
        end
      end
      ST_MULX, ST_MULY: prod_q <= PQW'(mul_p);
      ST_CLPX: begin
        x0_q <= cl_int;
        x1_q <= cl_next;
        fx_q <= cl_frac;
      end
      ST_CLPY: begin
        y0_q <= cl_int;
        y1_q <= cl_next;
        fy_q <= cl_frac;
      end
      ST_READ: wgt_q <= 17'(mul_p);
      ST_ACC: begin
        case (chan_q)
          2'd0:    acc_q[0] <= acc_cur + 24'(mul_p);
          2'd1:    acc_q[1] <= acc_cur + 24'(mul_p);
          default: acc_q[2] <= acc_cur + 24'(mul_p);
        endcase
      end
      ST_NORM: begin
        case (chan_q)
          2'd0:    color_q[0] <= ChanW'(mul_p >> RecipShift);
          2'd1:    color_q[1] <= ChanW'(mul_p >> RecipShift);
          default: color_q[2] <= ChanW'(mul_p >> RecipShift);
        endcase
      end
      default: ;
    endcase
    if (out_load) begin
      out_q.red_out      <= color_q[0];
      out_q.green_out    <= color_q[1];
      out_q.blue_out     <= color_q[2];
      out_q.is_padding   <= res_pad_q;
      out_q.out_of_range <= res_oor_q;
      out_q.pad_left     <= 10'(pad_l_q);
      out_q.pad_top      <= 10'(pad_t_q);
      out_q.scale_fixed  <= scale_q;
    end
  end

endmodule
